FILE: sv/bdpc_pkg.sv
package bdpc_pkg;

  // Fixed field widths
  localparam int RAW_W      = 4;
  localparam int NOW_W      = 32;
  localparam int CNT_W      = 4;
  localparam int LP_W       = 16;
  localparam int CODE_W     = 2;
  localparam int NUM_CODES  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Defaults for the top-level parameters
  localparam int DEFAULT_NUM_BUTTONS = 4;
  localparam int DEFAULT_TIME_BITS   = 32;

  // Register reset values
  localparam logic [CNT_W-1:0] DEBOUNCE_RESET   = 4'd5;
  localparam logic [LP_W-1:0]  LONG_PRESS_RESET = 16'd1000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_COUNT = 1'b0,
    CFG_LONG_PRESS_MS  = 1'b1
  } cfg_idx_t;

  // Per-button event codes
  typedef logic [CODE_W-1:0] code_t;
  localparam code_t CODE_NONE  = 2'd0;
  localparam code_t CODE_SHORT = 2'd1;
  localparam code_t CODE_LONG  = 2'd2;

endpackage

FILE: sv/bdpc_in_if.sv
interface bdpc_in_if import bdpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_levels;
  logic [NOW_W-1:0] now_ms;

  modport source (output valid, output raw_levels, output now_ms, input ready);
  modport sink   (input valid, input raw_levels, input now_ms, output ready);
endinterface

FILE: sv/bdpc_out_if.sv
interface bdpc_out_if import bdpc_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t code_b0;
  code_t code_b1;
  code_t code_b2;
  code_t code_b3;

  modport source (output valid, output code_b0, output code_b1, output code_b2,
                  output code_b3, input ready);
  modport sink   (input valid, input code_b0, input code_b1, input code_b2,
                  input code_b3, output ready);
endinterface

FILE: sv/button_debounce_press_classifier.sv
// A poll is held in the input register, then its result (if any) in the result register.
// Throughput: one poll per cycle while the result register is free or drains;
// the input register and the result register let a new poll enter while a
// finished result waits to be taken. The per-button state update is one pass
// of lane logic, set by one TIME_BITS-wide subtract and compare per button.
// Reset (synchronous, rst_n low): all button state cleared, registers to defaults.
module button_debounce_press_classifier import bdpc_pkg::*; #(
  parameter int NUM_BUTTONS = DEFAULT_NUM_BUTTONS,
  parameter int TIME_BITS   = DEFAULT_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bdpc_in_if.sink               in_chan,
  bdpc_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [CNT_W-1:0] debounce_r;
  logic [LP_W-1:0]  long_press_r;

  // Input register stage
  logic             s1_valid_r;
  logic [RAW_W-1:0] s1_raw_r;
  logic [NOW_W-1:0] s1_now_r;

  // Per-button state
  logic [NUM_BUTTONS-1:0] stable_r;
  logic [NUM_BUTTONS-1:0] long_r;
  logic [NUM_BUTTONS-1:0] short_r;
  logic [NUM_BUTTONS-1:0] pend_r;
  logic [NUM_BUTTONS-1:0] held_r;
  logic [CNT_W-1:0]       cnt_r  [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   ctime_r[NUM_BUTTONS];

  // Next-state values
  logic [NUM_BUTTONS-1:0] stable_nxt;
  logic [NUM_BUTTONS-1:0] long_nxt;
  logic [NUM_BUTTONS-1:0] short_nxt;
  logic [NUM_BUTTONS-1:0] pend_nxt;
  logic [NUM_BUTTONS-1:0] held_nxt;
  logic [CNT_W-1:0]       cnt_nxt  [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   ctime_nxt[NUM_BUTTONS];

  // Result register
  logic  out_valid_r;
  code_t code_r  [NUM_CODES];
  code_t code_nxt[NUM_CODES];

  // Classify stage intermediates
  logic [NUM_BUTTONS-1:0] long_c;
  logic [NUM_BUTTONS-1:0] short_c;
  logic [NUM_BUTTONS-1:0] pend_c;
  logic                   any_event;

  // Handshake
  logic out_free;
  logic s1_go;

  // Poll time and raw levels, widened to the design's sizes. Buttons past the
  // raw field read a zero bit, so they look pressed.
  logic [TIME_BITS+NOW_W-1:0]   now_wide;
  logic [TIME_BITS-1:0]         now_t;
  logic [NUM_BUTTONS+RAW_W-1:0] raw_wide;
  logic [TIME_BITS-1:0]         long_limit;

  assign now_wide   = {{TIME_BITS{1'b0}}, s1_now_r};
  assign now_t      = now_wide[TIME_BITS-1:0];
  assign raw_wide   = {{NUM_BUTTONS{1'b0}}, s1_raw_r};
  assign long_limit = TIME_BITS'(long_press_r);

  // Advance the input stage whenever the result register is free or drains.
  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_go         = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;

  // ---------------------------------------------------------------------------
  // Per-button lanes: debounce, classify, then report/clear.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic                 pressed;
    logic [CNT_W-1:0]     cnt_a;
    logic                 toggle;
    logic                 stab;
    logic [TIME_BITS-1:0] ct;
    logic [TIME_BITS-1:0] elapsed;
    code_t                code_pad[NUM_BUTTONS+NUM_CODES];

    for (int b = 0; b < NUM_BUTTONS + NUM_CODES; b++) begin
      code_pad[b] = CODE_NONE;
    end

    for (int b = 0; b < NUM_BUTTONS; b++) begin
      // Debounce: count up on disagreement, down (not below zero) on agreement.
      pressed = !raw_wide[b];
      cnt_a   = cnt_r[b];
      if (pressed == stable_r[b] && cnt_r[b] != '0) begin
        cnt_a = cnt_r[b] - CNT_W'(1);
      end
      if (pressed != stable_r[b]) begin
        cnt_a = cnt_r[b] + CNT_W'(1);
      end
      toggle       = (cnt_a >= debounce_r);
      stab         = stable_r[b] ^ toggle;
      ct           = toggle ? now_t : ctime_r[b];
      stable_nxt[b] = stab;
      cnt_nxt[b]    = toggle ? '0 : cnt_a;
      ctime_nxt[b]  = ct;

      // Classify against the freshly debounced level.
      long_c[b]   = long_r[b];
      short_c[b]  = short_r[b];
      pend_c[b]   = pend_r[b];
      held_nxt[b] = held_r[b];
      elapsed     = now_t - ct;
      if (stab && !held_r[b]) begin
        if (elapsed > long_limit && !long_r[b]) begin
          long_c[b]   = 1'b1;
          short_c[b]  = 1'b0;
          pend_c[b]   = 1'b1;
          held_nxt[b] = 1'b1;
        end else begin
          // Pressed and not yet long: mark short on every poll.
          short_c[b] = 1'b1;
        end
      end else if (!stab) begin
        if (short_r[b]) begin
          pend_c[b] = 1'b1;
        end
        held_nxt[b] = 1'b0;
      end
    end

    any_event = |pend_c;

    // Report every button once any event is pending; clear what is reported.
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      long_nxt[b]  = long_c[b];
      short_nxt[b] = short_c[b];
      pend_nxt[b]  = pend_c[b];
      if (any_event) begin
        if (long_c[b]) begin
          code_pad[b] = CODE_LONG;
          long_nxt[b] = 1'b0;
          pend_nxt[b] = 1'b0;
        end else if (short_c[b]) begin
          code_pad[b]  = CODE_SHORT;
          short_nxt[b] = 1'b0;
          pend_nxt[b]  = 1'b0;
        end
      end
    end

    for (int c = 0; c < NUM_CODES; c++) begin
      code_nxt[c] = code_pad[c];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RESET;
      long_press_r <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE_COUNT: debounce_r   <= cfg_data[CNT_W-1:0];
        CFG_LONG_PRESS_MS:  long_press_r <= cfg_data[LP_W-1:0];
        default:            ;
      endcase
    end
  end

  // Input register: load on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_raw_r <= in_chan.raw_levels;
      s1_now_r <= in_chan.now_ms;
    end
  end

  // Button state: commit the lane results when the poll advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= '0;
      long_r   <= '0;
      short_r  <= '0;
      pend_r   <= '0;
      held_r   <= '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        cnt_r[b]   <= '0;
        ctime_r[b] <= '0;
      end
    end else if (s1_go) begin
      stable_r <= stable_nxt;
      long_r   <= long_nxt;
      short_r  <= short_nxt;
      pend_r   <= pend_nxt;
      held_r   <= held_nxt;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        cnt_r[b]   <= cnt_nxt[b];
        ctime_r[b] <= ctime_nxt[b];
      end
    end
  end

  // Result register: hold until taken; polls with no event leave no result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && any_event;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && any_event) begin
      for (int c = 0; c < NUM_CODES; c++) begin
        code_r[c] <= code_nxt[c];
      end
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.code_b0 = code_r[0];
  assign out_chan.code_b1 = code_r[1];
  assign out_chan.code_b2 = code_r[2];
  assign out_chan.code_b3 = code_r[3];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_go |=> ($stable(stable_r) && $stable(held_r) && $stable(pend_r)))
    else $error("button state changed without an advancing poll");

  a_report_clears_long: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && any_event) |=> (long_r == '0))
    else $error("long flag survived a report");

  a_held_only_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r & ~stable_r) == '0)
    else $error("button blocked while released");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import bdpc_pkg::*;

  localparam int BUTTONS       = DEFAULT_NUM_BUTTONS;
  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off in the backpressure test
  localparam int SETTLE_CYCLES = 4;    // extra settling after the last report is taken
  localparam int PHASE_POLLS   = 250;  // seven random phases, about 1750 polls
  localparam int RANDOM_PHASES = 7;

  // One report: entry i holds the code of button i
  typedef logic [NUM_CODES-1:0][CODE_W-1:0] code_vec_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bdpc_in_if  in_if ();
  bdpc_out_if out_if ();

  button_debounce_press_classifier u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  int        fail_count = 0;
  bit        idle_off   = 1'b0;  // suppress random gaps on both channels
  bit        hold_req   = 1'b0;  // ask the result sink for one long hold-off
  code_vec_t reports_due[$];     // predicted reports, oldest first

  // --------------------------------------------------------------------------
  // Button model: debounce filter plus press classifier, one copy per button
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]   dbnc_thresh;
  logic [LP_W-1:0]    long_ms;
  logic [BUTTONS-1:0] btn_pressed;   // debounced level, 1 = pressed
  logic [CNT_W-1:0]   btn_count [BUTTONS];
  logic [NOW_W-1:0]   btn_since [BUTTONS];
  logic [BUTTONS-1:0] btn_long;
  logic [BUTTONS-1:0] btn_short;
  logic [BUTTONS-1:0] btn_pend;
  logic [BUTTONS-1:0] btn_block;

  function automatic void reset_buttons();
    dbnc_thresh = DEBOUNCE_RESET;
    long_ms     = LONG_PRESS_RESET;
    btn_pressed = '0;
    btn_long    = '0;
    btn_short   = '0;
    btn_pend    = '0;
    btn_block   = '0;
    for (int b = 0; b < BUTTONS; b++) begin
      btn_count[b] = '0;
      btn_since[b] = '0;
    end
  endfunction

  // Advance every button by one poll; return 1 when the poll yields a report.
  function automatic bit classify_poll(input logic [RAW_W-1:0] raw,
                                       input logic [NOW_W-1:0] now,
                                       output code_vec_t report);
    logic             pressed;
    logic [NOW_W-1:0] elapsed;
    bit               any;

    report = '0;
    any    = 1'b0;
    // Debounce: count up on disagreement, down (not below zero) on agreement
    for (int b = 0; b < BUTTONS; b++) begin
      pressed = ~raw[b];
      if (pressed == btn_pressed[b] && btn_count[b] != '0)
        btn_count[b] = btn_count[b] - 1'b1;
      if (pressed != btn_pressed[b])
        btn_count[b] = btn_count[b] + 1'b1;  // wraps at four bits
      if (btn_count[b] >= dbnc_thresh) begin
        btn_count[b]   = '0;
        btn_pressed[b] = ~btn_pressed[b];
        btn_since[b]   = now;
      end
    end
    // Classify: long once past the threshold, then block until release
    for (int b = 0; b < BUTTONS; b++) begin
      if (btn_pressed[b] && !btn_block[b]) begin
        elapsed = now - btn_since[b];  // modulo 2^32
        if (elapsed > NOW_W'(long_ms) && !btn_long[b]) begin
          btn_long[b]  = 1'b1;
          btn_short[b] = 1'b0;
          btn_pend[b]  = 1'b1;
          btn_block[b] = 1'b1;
        end else begin
          btn_short[b] = 1'b1;  // reported as short even while still held
        end
      end else if (!btn_pressed[b]) begin
        if (btn_short[b])
          btn_pend[b] = 1'b1;
        btn_block[b] = 1'b0;
      end
    end
    for (int b = 0; b < BUTTONS; b++)
      if (btn_pend[b])
        any = 1'b1;
    if (!any)
      return 1'b0;
    // Report every button and clear the flag it reports
    for (int b = 0; b < BUTTONS; b++) begin
      report[b] = CODE_NONE;
      if (btn_long[b]) begin
        report[b]   = CODE_LONG;
        btn_long[b] = 1'b0;
        btn_pend[b] = 1'b0;
      end else if (btn_short[b]) begin
        report[b]    = CODE_SHORT;
        btn_short[b] = 1'b0;
        btn_pend[b]  = 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: check each result transaction, then predict from each poll
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    code_vec_t got;
    code_vec_t want;
    code_vec_t pred;

    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.code_b3, out_if.code_b2, out_if.code_b1, out_if.code_b0};
        if (reports_due.size() == 0) begin
          $error("result with no report pending: %h", got);
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          for (int i = 0; i < NUM_CODES; i++)
            if (got[i] !== want[i]) begin
              $error("code_b%0d: expected %0d, actual %0d", i, want[i], got[i]);
              fail_count++;
            end
        end
      end
      // A poll accepted here passes the input and result registers before its result can show
      if (in_if.valid && in_if.ready)
        if (classify_poll(in_if.raw_levels, in_if.now_ms, pred))
          reports_due.push_back(pred);
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int idle_gap();
    int pick;

    pick = $urandom_range(0, 99);
    if (idle_off || pick < 55)
      return 0;
    if (pick < 88)
      return $urandom_range(1, 3);
    if (pick < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Result sink: random ready, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int run_left;
    int hold_left;
    int stall;
    bit rdy;

    run_left  = 0;
    hold_left = 0;
    rdy       = 1'b1;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // Hold ready low and count the hold-off here
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          if (rdy) begin
            stall = idle_gap();
            if (stall > 0) begin
              rdy      = 1'b0;
              run_left = stall;
            end else begin
              run_left = $urandom_range(1, 8);
            end
          end else begin
            rdy      = 1'b1;
            run_left = $urandom_range(1, 8);
          end
        end
        run_left--;
        out_if.ready <= rdy || idle_off;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Offer one poll after a random gap; return at the edge that accepts it.
  // Leave valid high so a back-to-back poll needs no second assignment.
  task automatic send_poll(input logic [RAW_W-1:0] raw, input logic [NOW_W-1:0] now);
    int gap;

    gap = idle_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.raw_levels <= raw;
    in_if.now_ms     <= now;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stop offering polls, wait for every predicted report, then let the
  // last poll (which may yield nothing) clear the pipeline.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register while the block is idle and mirror it in the model
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_DEBOUNCE_COUNT: dbnc_thresh = value[CNT_W-1:0];
      CFG_LONG_PRESS_MS:  long_ms     = value[LP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: five polls to settle a press, five to settle the release
  task automatic test_default_registers();
    for (int i = 0; i < 5; i++)
      send_poll(4'b1110, NOW_W'(10 + i));
    for (int i = 0; i < 5; i++)
      send_poll(4'b1111, NOW_W'(15 + i));
    drain_results();
  endtask

  // Short, long, blocked, short while held, time wrap, all buttons at once
  task automatic test_press_classes();
    write_reg(CFG_DEBOUNCE_COUNT, 16'd1);
    // Long press on button 2: exactly at the threshold stays short
    send_poll(4'b1011, 32'd100);
    send_poll(4'b1011, 32'd1100);
    send_poll(4'b1011, 32'd1101);
    send_poll(4'b1011, 32'd5000);   // blocked: flags hold
    send_poll(4'b1111, 32'd5001);   // release after long: no event
    // Button 3 held while button 0 taps: both report short
    send_poll(4'b0111, 32'd6000);
    send_poll(4'b0110, 32'd6001);
    send_poll(4'b0111, 32'd6002);
    send_poll(4'b1111, 32'd6003);
    // Press across the time wrap
    send_poll(4'b1101, 32'hFFFF_FFF0);
    send_poll(4'b1101, 32'h0000_0010);
    send_poll(4'b1111, 32'h0000_0020);
    // All pins down, then all up
    send_poll(4'b0000, 32'hFFFF_FFFF);
    send_poll(4'b1111, 32'h0000_0000);
    drain_results();
  endtask

  // Long threshold at zero and at its maximum
  task automatic test_long_threshold_extremes();
    write_reg(CFG_LONG_PRESS_MS, 16'd0);
    send_poll(4'b1101, 32'd500);
    send_poll(4'b1101, 32'd500);    // zero elapsed is not long
    send_poll(4'b1101, 32'd501);
    send_poll(4'b1111, 32'd502);
    drain_results();
    write_reg(CFG_LONG_PRESS_MS, 16'hFFFF);
    send_poll(4'b0111, 32'h10);
    send_poll(4'b0111, 32'h10 + 32'd65535);
    send_poll(4'b0111, 32'h10 + 32'd65536);
    send_poll(4'b1111, 32'h10 + 32'd65537);
    drain_results();
  endtask

  // Counter left above a lowered threshold, then a threshold of zero
  task automatic test_debounce_threshold_changes();
    write_reg(CFG_DEBOUNCE_COUNT, 16'd15);
    for (int i = 0; i < 7; i++)
      send_poll(4'b1110, NOW_W'(9000 + i));
    drain_results();
    write_reg(CFG_DEBOUNCE_COUNT, 16'd3);
    send_poll(4'b1110, 32'd9010);   // count already past three: toggles now
    for (int i = 0; i < 3; i++)
      send_poll(4'b1111, NOW_W'(9011 + i));
    drain_results();
    // With zero every button toggles on every poll, whatever the pins say
    write_reg(CFG_DEBOUNCE_COUNT, 16'd0);
    send_poll(4'b1111, 32'd9100);
    send_poll(4'b0000, 32'd9101);
    send_poll(4'b0101, 32'd9102);
    send_poll(4'b1010, 32'd9103);
    drain_results();
  endtask

  // Hold the receiver off while taps keep coming, then pause until drained
  task automatic test_backpressure();
    write_reg(CFG_DEBOUNCE_COUNT, 16'd1);
    write_reg(CFG_LONG_PRESS_MS, 16'hFFFF);
    idle_off = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_poll((i % 2 == 0) ? 4'b1110 : 4'b1111, NOW_W'(20000 + i));
    idle_off = 1'b0;
    drain_results();
  endtask

  // Buttons that change now and then, with contact bounce and some junk polls
  task automatic run_traffic(input int polls);
    logic [BUTTONS-1:0] held;
    logic [RAW_W-1:0]   raw;
    logic [NOW_W-1:0]   now;
    int                 pick;

    held = '0;
    if ($urandom_range(0, 3) == 0)
      now = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    else
      now = $urandom();
    repeat (polls) begin
      for (int b = 0; b < BUTTONS; b++)
        if ($urandom_range(0, 19) == 0)
          held[b] = ~held[b];
      raw  = ~held;
      pick = $urandom_range(0, 99);
      if (pick < 12)
        raw = raw ^ RAW_W'($urandom_range(1, 15));  // bounce on some pins
      else if (pick < 16)
        raw = RAW_W'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 80)
        now = now + $urandom_range(0, 20);
      else if (pick < 96)
        now = now + $urandom_range(21, 400);
      else
        now = now + $urandom_range(1000, 70000);
      send_poll(raw, now);
    end
  endtask

  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] dbnc;
    logic [CFG_DATA_W-1:0] lp;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      case (p)
        0: begin dbnc = 16'd1;  lp = 16'd0;    end
        1: begin dbnc = 16'd15; lp = 16'hFFFF; end
        2: begin dbnc = 16'd2;  lp = 16'd50;   end
        3: begin
          dbnc = CFG_DATA_W'($urandom_range(1, 15));
          lp   = CFG_DATA_W'($urandom_range(0, 2000));
        end
        default: begin
          dbnc = CFG_DATA_W'($urandom_range(1, 5));
          lp   = CFG_DATA_W'($urandom_range(0, 400));
        end
      endcase
      write_reg(CFG_DEBOUNCE_COUNT, dbnc);
      write_reg(CFG_LONG_PRESS_MS, lp);
      idle_off = (p == 4);  // one phase runs at full rate on both sides
      run_traffic(PHASE_POLLS);
    end
    idle_off = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_DEBOUNCE_COUNT;
    cfg_data         <= '0;
    in_if.valid      <= 1'b0;
    in_if.raw_levels <= '1;
    in_if.now_ms     <= '0;
    reset_buttons();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_registers();
    test_press_classes();
    test_long_threshold_extremes();
    test_debounce_threshold_changes();
    test_backpressure();
    test_random_traffic();
    drain_results();

    if (fail_count == 0 && reports_due.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #15_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

FILE: button_debounce_press_classifier.f
sv/bdpc_pkg.sv
sv/bdpc_in_if.sv
sv/bdpc_out_if.sv
sv/button_debounce_press_classifier.sv
tb/tb.sv
